// ===== rtl/prm_pkg.sv =====
// prm_pkg: types, constants and codes shared by the pseudo-rate modulator
// files. No dependencies.
package prm_pkg;

  localparam int AXES_DEF = 3;
  localparam int AXES_MAX = 3;
  localparam int THR_W    = 15;
  localparam int VAL_W    = 16;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  // decay 0.9231 as signed q1.12, step 0.07688 as signed q5.12
  localparam logic signed [13:0] DECAY_Q12  = 14'sd3781;
  localparam logic signed [17:0] STEP_Q12   = 18'sd315;
  localparam logic [THR_W-1:0]   THR_RESET  = 15'd410;
  localparam logic signed [17:0] SAT_MAX    = 18'sd32767;
  localparam logic signed [17:0] SAT_MIN    = -18'sd32768;
  localparam logic signed [28:0] ROUND_HALF = 29'sd2048;

  typedef logic [1:0] fire_t;
  localparam fire_t FIRE_NONE  = 2'd0;
  localparam fire_t FIRE_ABOVE = 2'd1;
  localparam fire_t FIRE_BELOW = 2'd2;

  typedef enum logic [1:0] {
    REG_THR_X = 2'd0,
    REG_THR_Y = 2'd1,
    REG_THR_Z = 2'd2
  } reg_idx_t;

  typedef logic [AXES_MAX-1:0][THR_W-1:0] thr_arr_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] command_x;
    logic signed [VAL_W-1:0] command_y;
    logic signed [VAL_W-1:0] command_z;
    logic [7:0]              base_pulse_word;
  } cmd_t;

  typedef struct packed {
    logic [7:0] pulse_word;
    fire_t      fire_x;
    fire_t      fire_y;
    fire_t      fire_z;
  } res_t;

endpackage

// ===== rtl/pseudo_rate_modulator.sv =====
// Pseudo-rate modulator, three axes, one result beat per command beat.
// A command beat is captured in an input register, and its fire codes and
// pulse word then land in the result register, from which the result beat
// is offered. One beat is taken every clock while the result side keeps
// up. Each axis's feedback register closes a loop through a 16x12
// constant multiply, rounding, step add and compare; that loop sets the
// clock. Thresholds reset to 410; the user must write them over the apb
// port only while the block is idle, which the block itself does not enforce.
// No clearing pass after reset.
// Depends on prm_pkg, prm_regs, prm_axis.
module pseudo_rate_modulator #(
  parameter int AXES = prm_pkg::AXES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  prm_pkg::cmd_t                  cmd,
  output logic                           res_valid,
  input  logic                           res_stall,
  output prm_pkg::res_t                  res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [prm_pkg::PADDR_W-1:0]    paddr,
  input  logic [prm_pkg::PDATA_W-1:0]    pwdata,
  output logic [prm_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);
  import prm_pkg::*;

  thr_arr_t                              thresholds;
  logic                                  s1_valid;
  cmd_t                                  s1_data;
  logic                                  advance;
  logic                                  update;
  logic [AXES_MAX-1:0][VAL_W-1:0]        commands;
  fire_t [AXES_MAX-1:0]                  fire;
  res_t                                  res_next;

  prm_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .thresholds (thresholds)
  );

  assign advance   = !res_valid || !res_stall;
  assign cmd_stall = s1_valid && !advance;
  assign update    = s1_valid && advance;

  assign commands[0] = s1_data.command_x;
  assign commands[1] = s1_data.command_y;
  assign commands[2] = s1_data.command_z;

  for (genvar i = 0; i < AXES_MAX; i++) begin : g_axis
    if (i < AXES) begin : g_on
      prm_axis u_axis (
        .clk       (clk),
        .rst       (rst),
        .update    (update),
        .command   ($signed(commands[i])),
        .threshold (thresholds[i]),
        .fire      (fire[i])
      );
    end else begin : g_off
      assign fire[i] = FIRE_NONE;
    end
  end

  // positive line sits at bit 2i+3, negative line at 2i+2
  always_comb begin
    res_next.pulse_word = s1_data.base_pulse_word;
    for (int i = 0; i < AXES_MAX; i++) begin
      if (fire[i] == FIRE_ABOVE) res_next.pulse_word[2*i+3] = 1'b1;
      if (fire[i] == FIRE_BELOW) res_next.pulse_word[2*i+2] = 1'b1;
    end
    res_next.fire_x = fire[0];
    res_next.fire_y = fire[1];
    res_next.fire_z = fire[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (!cmd_stall) begin
        s1_valid <= cmd_valid;
      end
      if (advance) begin
        res_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd_stall && cmd_valid) begin
      s1_data <= cmd;
    end
    if (update) begin
      res <= res_next;
    end
  end

endmodule

// ===== rtl/prm_regs.sv =====
// prm_regs: apb-style register file holding the three switching thresholds.
// Depends on prm_pkg.
module prm_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [prm_pkg::PADDR_W-1:0]    paddr,
  input  logic [prm_pkg::PDATA_W-1:0]    pwdata,
  output logic [prm_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready,
  output prm_pkg::thr_arr_t              thresholds
);
  import prm_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresholds <= {AXES_MAX{THR_RESET}};
    end else if (wr_en) begin
      unique case (idx)
        REG_THR_X: thresholds[0] <= pwdata[THR_W-1:0];
        REG_THR_Y: thresholds[1] <= pwdata[THR_W-1:0];
        REG_THR_Z: thresholds[2] <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_THR_X: prdata = PDATA_W'(thresholds[0]);
      REG_THR_Y: prdata = PDATA_W'(thresholds[1]);
      REG_THR_Z: prdata = PDATA_W'(thresholds[2]);
      default:   prdata = '0;
    endcase
  end

endmodule

// ===== rtl/prm_axis.sv =====
// prm_axis: one axis of the modulator, switching decision plus the
// feedback register and its decay/step update. Depends on prm_pkg.
module prm_axis (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                update,
  input  logic signed [prm_pkg::VAL_W-1:0]    command,
  input  logic [prm_pkg::THR_W-1:0]           threshold,
  output prm_pkg::fire_t                      fire
);
  import prm_pkg::*;

  logic signed [VAL_W-1:0] feedback;
  logic signed [VAL_W-1:0] feedback_next;
  logic signed [17:0]      err;
  logic signed [17:0]      thr_s;
  logic signed [28:0]      prod;
  logic signed [28:0]      rnd;
  logic signed [17:0]      decayed;
  logic signed [17:0]      nr;

  assign err   = 18'(command) - 18'(feedback);
  assign thr_s = $signed({3'b000, threshold});

  always_comb begin
    if (err > thr_s) begin
      fire = FIRE_ABOVE;
    end else if (err < -thr_s) begin
      fire = FIRE_BELOW;
    end else begin
      fire = FIRE_NONE;
    end
  end

  // exact product, round half up, then floor by arithmetic shift
  assign prod    = 29'(feedback) * 29'(DECAY_Q12);
  assign rnd     = prod + ROUND_HALF;
  assign decayed = 18'(rnd >>> 12);

  always_comb begin
    case (fire)
      FIRE_ABOVE: nr = decayed + STEP_Q12;
      FIRE_BELOW: nr = decayed - STEP_Q12;
      default:    nr = decayed;
    endcase
    if (nr > SAT_MAX) begin
      feedback_next = SAT_MAX[VAL_W-1:0];
    end else if (nr < SAT_MIN) begin
      feedback_next = SAT_MIN[VAL_W-1:0];
    end else begin
      feedback_next = nr[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      feedback <= '0;
    end else if (update) begin
      feedback <= feedback_next;
    end
  end

endmodule

// ===== rtl/prm_checker.sv =====
// prm_checker: port-level assertions for pseudo_rate_modulator, bound to
// the top level below. Depends on prm_pkg.
module prm_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_stall,
  input logic          res_valid,
  input logic          res_stall,
  input prm_pkg::res_t res
);
  import prm_pkg::*;

  // a held result beat stays put
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  // input only backs up when the result side is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> res_valid && res_stall)
    else $error("command stalled with room downstream");

  a_no_res_after_rst: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result beat right after reset");

  a_fire_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.fire_x != 2'd3 && res.fire_y != 2'd3 && res.fire_z != 2'd3)
    else $error("illegal fire code");

  a_word_x: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.fire_x != FIRE_ABOVE || res.pulse_word[3]) &&
                  (res.fire_x != FIRE_BELOW || res.pulse_word[2]))
    else $error("x fire code not reflected in pulse word");

endmodule

bind pseudo_rate_modulator prm_checker u_prm_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_stall (cmd_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
